### rtl/md5_pkg.sv
// MD5 package: widths, round constants, message schedule and round helpers.
`default_nettype none

package md5_pkg;

  localparam int BYTE_W    = 8;
  localparam int USER_W    = 1;
  localparam int OUT_W     = 136;
  localparam int BUF_WORDS = 16;

  typedef logic [31:0] word_t;

  localparam word_t INIT_A = 32'h67452301;
  localparam word_t INIT_B = 32'hefcdab89;
  localparam word_t INIT_C = 32'h98badcfe;
  localparam word_t INIT_D = 32'h10325476;

  localparam word_t K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Message word used in round r (only r mod 16 matters within a stage).
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'((lo << 2) + lo + 4'd1);
      2'd2:    idx = 4'((lo << 1) + lo + 4'd5);
      2'd3:    idx = 4'((lo << 3) - lo);
      default: idx = lo;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0:    s = 5'd7;
      4'h1:    s = 5'd12;
      4'h2:    s = 5'd17;
      4'h3:    s = 5'd22;
      4'h4:    s = 5'd5;
      4'h5:    s = 5'd9;
      4'h6:    s = 5'd14;
      4'h7:    s = 5'd20;
      4'h8:    s = 5'd4;
      4'h9:    s = 5'd11;
      4'ha:    s = 5'd16;
      4'hb:    s = 5'd23;
      4'hc:    s = 5'd6;
      4'hd:    s = 5'd10;
      4'he:    s = 5'd15;
      4'hf:    s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

  function automatic word_t round_fn(input logic [1:0] stage, input word_t b,
                                     input word_t c, input word_t d);
    word_t f;
    case (stage)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

### rtl/md5_message_digest_unit.sv
// MD5 digest unit: byte stream in, 128-bit digest plus byte fold out.
`default_nettype none

// Takes one message byte per item (s_tuser[0] marks the byte as real, s_tlast
// ends the message) and returns one digest item per message. Bytes go into a
// 16 x 32-bit block buffer RAM, one per cycle, while the buffer fills. The
// 64th byte starts a compression in which no item is accepted: a prime step
// for the single RAM read port, 64 rounds at one round per cycle (each round
// reads its message word from that port), then one chaining add. On end of
// message the pad sequencer writes one byte per cycle from the end of data
// to byte 63 (0x80, zeros, bit length little-endian), then compresses; if the
// 0x80 mark lands at byte 56 or later, a second pad block and another
// compression follow. The digest is then loaded into the output register
// and the chaining state re-initializes; the next message may start while
// that result waits for m_tready. Bytes of the digest are little endian:
// m_tdata[7:0] is digest byte 0.
module md5_message_digest_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [md5_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
  input  wire logic [md5_pkg::USER_W-1:0]    s_tuser,   // [0] byte_valid
  input  wire logic                          s_tlast,   // end_of_message
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [md5_pkg::OUT_W-1:0]          m_tdata    // [63:0] digest_low,
                                                        // [127:64] digest_high,
                                                        // [135:128] digest_fold
);
  import md5_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_PRIME  = 3'd2;
  localparam logic [2:0] ST_ROUND  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]  state;
  logic [5:0]  fill_index;
  logic [63:0] bit_count;
  word_t       ch [4];

  // pad sequencer
  logic [5:0]  pad_ptr;
  logic        mark;       // next pad byte is the 0x80 mark
  logic        extra;      // mark landed past byte 55: this block is zeros only
  logic        pad_pend;   // another pad block follows the running compression
  logic        final_blk;  // running compression is the last of the message

  // round datapath
  logic [5:0]  rnd;
  word_t       va, vb, vc, vd;
  word_t       ak;         // a + K[rnd], formed ahead of its round

  logic               out_valid;
  logic [OUT_W-1:0]   out_data;

  // block buffer RAM
  word_t       buf_mem [BUF_WORDS];
  word_t       rd_word;
  logic        we;
  logic [5:0]  waddr;
  logic [7:0]  wbyte;
  logic [3:0]  raddr;

  logic        accept;
  logic        byte_in;
  logic [5:0]  rnd_inc;
  logic [7:0]  pad_byte;
  logic        extra_now;
  word_t       f_val;
  word_t       sum;
  word_t       b_new;
  logic [7:0]  fold;
  logic        emit_go;    // digest loads into the output register this cycle

  assign accept   = s_tvalid && s_tready;
  assign byte_in  = s_tuser[0];
  assign rnd_inc  = rnd + 6'd1;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign emit_go  = (state == ST_EMIT) && (!out_valid || m_tready);

  // Pad byte: mark first, then zeros, with the length in bytes 56..63 of
  // the closing block.
  always_comb begin
    if (mark) begin
      pad_byte = 8'h80;
    end else if (pad_ptr >= 6'd56 && !extra) begin
      pad_byte = bit_count[{pad_ptr[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
    extra_now = extra || (mark && pad_ptr >= 6'd56);
  end

  always_comb begin
    we    = 1'b0;
    waddr = fill_index;
    wbyte = s_tdata;
    raddr = msg_index(rnd_inc);
    case (state)
      ST_IDLE: begin
        we = accept && byte_in;
      end
      ST_PAD: begin
        we    = 1'b1;
        waddr = pad_ptr;
        wbyte = pad_byte;
      end
      ST_PRIME: begin
        raddr = msg_index(6'd0);
      end
      default: begin
      end
    endcase
  end

  // Writes and round reads never share a cycle, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (we) begin
      buf_mem[waddr[5:2]][{waddr[1:0], 3'b000} +: 8] <= wbyte;
    end
    rd_word <= buf_mem[raddr];
  end

  always_comb begin
    f_val = round_fn(rnd[5:4], vb, vc, vd);
    sum   = ak + f_val + rd_word;
    b_new = vb + rotl(sum, rot_amt(rnd));
  end

  always_comb begin
    fold = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        fold = fold ^ ch[i][8*j +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_index <= '0;
      bit_count  <= '0;
      ch[0]      <= INIT_A;
      ch[1]      <= INIT_B;
      ch[2]      <= INIT_C;
      ch[3]      <= INIT_D;
      mark       <= 1'b0;
      extra      <= 1'b0;
      pad_pend   <= 1'b0;
      final_blk  <= 1'b0;
      rnd        <= '0;
      pad_ptr    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (m_tready && !emit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (byte_in) begin
              fill_index <= fill_index + 6'd1;
              bit_count  <= bit_count + 64'd8;
            end
            if (byte_in && fill_index == 6'd63) begin
              // buffer full: compress first, pad afterwards if message ends
              state     <= ST_PRIME;
              pad_pend  <= s_tlast;
              mark      <= s_tlast;
              final_blk <= 1'b0;
            end else if (s_tlast) begin
              state   <= ST_PAD;
              pad_ptr <= byte_in ? fill_index + 6'd1 : fill_index;
              mark    <= 1'b1;
              extra   <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          pad_ptr <= pad_ptr + 6'd1;
          mark    <= 1'b0;
          extra   <= extra_now;
          if (pad_ptr == 6'd63) begin
            state     <= ST_PRIME;
            final_blk <= !extra_now;
            pad_pend  <= extra_now;
          end
        end
        ST_PRIME: begin
          va    <= ch[0];
          vb    <= ch[1];
          vc    <= ch[2];
          vd    <= ch[3];
          ak    <= ch[0] + K_TABLE[0];
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          va  <= vd;
          ak  <= vd + K_TABLE[rnd_inc];
          vd  <= vc;
          vc  <= vb;
          vb  <= b_new;
          rnd <= rnd_inc;
          if (rnd == 6'd63) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          ch[0] <= ch[0] + va;
          ch[1] <= ch[1] + vb;
          ch[2] <= ch[2] + vc;
          ch[3] <= ch[3] + vd;
          if (final_blk) begin
            state <= ST_EMIT;
          end else if (pad_pend) begin
            state    <= ST_PAD;
            pad_ptr  <= '0;
            extra    <= 1'b0;
            pad_pend <= 1'b0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // wait for the output register to free up
          if (emit_go) begin
            out_data   <= {fold, ch[3], ch[2], ch[1], ch[0]};
            out_valid  <= 1'b1;
            ch[0]      <= INIT_A;
            ch[1]      <= INIT_B;
            ch[2]      <= INIT_C;
            ch[3]      <= INIT_D;
            bit_count  <= '0;
            fill_index <= '0;
            final_blk  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/md5_checker.sv
// MD5 port checker and its bind to the top level.
`default_nettype none

module md5_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       s_tlast,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [md5_pkg::OUT_W-1:0]  m_tdata
);
  import md5_pkg::*;

  logic [7:0] fold_calc;

  always_comb begin
    fold_calc = '0;
    for (int i = 0; i < 16; i++) begin
      fold_calc = fold_calc ^ m_tdata[8*i +: 8];
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // fold byte agrees with the digest bytes
  a_fold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1 -: 8] == fold_calc)
    else $error("digest fold mismatch");

  // end of message always leads into padding or compression
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input open right after end of message");

  // a new digest only comes out of a busy phase
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("digest appeared without finalization");

endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### verif/tb_md5_message_digest_unit.sv
// Self-checking testbench for the MD5 byte-stream digest unit.
`timescale 1ns / 1ps

module tb_md5_message_digest_unit;
  import md5_pkg::*;

  // Timing knobs in clock cycles, and item and message counts.
  localparam int unsigned HOLD_CYCLES = 1000;  // long m_tready hold-off
  localparam int unsigned TAIL_CYCLES = 300;   // two pad blocks + two compressions
  localparam int unsigned RAND_ITEMS  = 850;   // message items in the random part
  localparam int unsigned RAND_MSGS   = 40;    // digests wanted from the random part

  // Per-round additive constants, in round order.
  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, four per stage.
  localparam int unsigned ROT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic [7:0]  fold;
    logic [63:0] high;
    logic [63:0] low;
  } digest_t;

  // DUT signals; every input starts at a known value.
  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [BYTE_W-1:0]  s_tdata  = '0;     // [7:0] data_byte
  logic [USER_W-1:0]  s_tuser  = '0;     // [0] byte_valid
  logic               s_tlast  = 1'b0;   // end_of_message
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;           // [63:0] low, [127:64] high, [135:128] fold

  // Predictor state: chaining words, bit count, block buffer, fill pointer.
  logic [31:0] chain [4];
  logic [63:0] msg_bits;
  logic [7:0]  blk [64];
  logic [5:0]  fill_ptr;

  digest_t     digest_q [$];   // digests expected, oldest first
  int unsigned mismatch_cnt = 0;

  // Knobs shared between the test tasks and the receiver.
  bit          tx_calm  = 1'b0;   // sender offers items back to back
  bit          rx_calm  = 1'b0;   // receiver draws no random stalls
  logic        hold_req = 1'b0;   // one-cycle pulse starts a long hold-off
  int unsigned rx_gap   = 0;
  int unsigned rx_hold  = 0;

  md5_message_digest_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic void md5_restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    msg_bits = '0;
    fill_ptr = '0;
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One 64-round compression of the current block into the chaining words.
  function automatic void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned m, st;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      st = i / 16;
      case (st)
        0: begin
          f = (b & c) | (~b & d);
          m = i % 16;
        end
        1: begin
          f = (b & d) | (c & ~d);
          m = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          m = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          m = (7 * i) % 16;
        end
      endcase
      t = a + f + SINE_K[i] + w[m];
      a = d;
      d = c;
      c = b;
      b = b + rol32(t, ROT_BY[4*st + i%4]);
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // Pad, run the last block(s), return the digest and start a new message.
  function automatic digest_t md5_finish();
    digest_t r;
    int unsigned n;
    n = fill_ptr;
    blk[n] = 8'h80;
    n = n + 1;
    if (n > 56) begin
      // Mark landed too late for the length field: spill into an extra block.
      while (n < 64) begin
        blk[n] = 8'h00;
        n = n + 1;
      end
      md5_compress();
      n = 0;
    end
    while (n < 56) begin
      blk[n] = 8'h00;
      n = n + 1;
    end
    for (int i = 0; i < 8; i++) begin
      blk[56+i] = msg_bits[8*i +: 8];
    end
    md5_compress();
    r.low  = {chain[1], chain[0]};
    r.high = {chain[3], chain[2]};
    r.fold = '0;
    for (int i = 0; i < 8; i++) begin
      r.fold = r.fold ^ r.low[8*i +: 8] ^ r.high[8*i +: 8];
    end
    md5_restart();
    return r;
  endfunction

  // Apply one accepted input item to the predictor.
  function automatic void md5_take_item(input logic [7:0] data, input bit valid,
                                        input bit last);
    if (valid) begin
      blk[fill_ptr] = data;
      fill_ptr      = fill_ptr + 6'd1;
      msg_bits      = msg_bits + 64'd8;
      if (fill_ptr == 6'd0) begin
        md5_compress();
      end
    end
    if (last) begin
      digest_q.push_back(md5_finish());
    end
  endfunction

  initial begin
    md5_restart();
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_gap(input bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  // tvalid is only lowered when a gap is drawn, so back-to-back items never
  // see a low-then-high pair in one step.
  task automatic send_item(input logic [7:0] data, input bit valid, input bit last);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= data;
    s_tuser[0] <= valid;
    s_tlast    <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    md5_take_item(data, valid, last);
  endtask

  // Drop tvalid, let every pending digest arrive, then let the pad and
  // compression machinery run out.
  task automatic wait_for_digests();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // One message of msg_len random bytes. With empty_tail the end mark rides
  // on a separate item without a byte; a zero-length message always does.
  // Idle items are sprinkled in as noise when noisy is set.
  task automatic send_message(input int unsigned msg_len, input bit empty_tail,
                              input bit noisy);
    bit tail;
    tail = empty_tail || (msg_len == 0);
    for (int unsigned k = 0; k < msg_len; k++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, !tail && (k == msg_len - 1));
    end
    if (tail) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // Lengths cluster around the pad boundaries: 55 bytes is the longest
  // message whose pad fits one block, 56 spills into a second block, 64 lands
  // exactly on a block edge and 120 repeats the 56 case one block later.
  function automatic int unsigned pick_msg_len();
    case ($urandom_range(0, 15))
      0:       return $urandom_range(55, 57);
      1:       return $urandom_range(63, 65);
      2:       return $urandom_range(119, 121);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stalls per result, plus an optional long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned gap;
    if (rst) begin
      m_tready <= 1'b1;
      rx_gap   <= 0;
      rx_hold  <= 0;
    end else if (hold_req) begin
      m_tready <= 1'b0;
      rx_hold  <= HOLD_CYCLES;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) begin
        m_tready <= 1'b1;
      end
    end else if (m_tvalid && m_tready) begin
      gap      = pick_gap(rx_calm);
      rx_gap   <= gap;
      m_tready <= (gap == 0);
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      if (rx_gap == 1) begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: each digest against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    digest_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest item: %h", m_tdata);
        mismatch_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (m_tdata[63:0] !== want.low) begin
          $error("digest_low: expected %h, got %h", want.low, m_tdata[63:0]);
          mismatch_cnt++;
        end
        if (m_tdata[127:64] !== want.high) begin
          $error("digest_high: expected %h, got %h", want.high, m_tdata[127:64]);
          mismatch_cnt++;
        end
        if (m_tdata[135:128] !== want.fold) begin
          $error("digest_fold: expected %h, got %h", want.fold, m_tdata[135:128]);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty final item straight after reset, then again after the re-init;
  // the byte lane carries junk that must be ignored.
  task automatic test_empty_message();
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    wait_for_digests();
  endtask

  // Classic three-letter text with the end mark on the last byte.
  task automatic test_short_text();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    wait_for_digests();
  endtask

  // Byte extremes, an idle item in the middle, end on an empty final item.
  task automatic test_byte_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    wait_for_digests();
  endtask

  // Single-byte messages back to back, no idling on either side.
  task automatic test_back_to_back();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h7f, 1'b1, 1'b1);
    wait_for_digests();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Receiver goes quiet for a long stretch while short messages keep coming;
  // once the output register is full the block has to stall its input.
  task automatic test_output_backpressure();
    tx_calm  = 1'b1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      send_message(3, 1'b0, 1'b0);
    end
    wait_for_digests();
    tx_calm = 1'b0;
  endtask

  // Bulk of the run: random messages with random idling, calm stretches,
  // noise items and the occasional full drain between messages.
  task automatic test_random_messages();
    int unsigned items_sent;
    int unsigned msgs_sent;
    int unsigned msg_len;
    items_sent = 0;
    msgs_sent  = 0;
    while (items_sent < RAND_ITEMS || msgs_sent < RAND_MSGS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      msg_len = pick_msg_len();
      send_message(msg_len, $urandom_range(0, 3) == 0, 1'b1);
      items_sent += msg_len + 1;
      msgs_sent++;
      if ($urandom_range(0, 7) == 0) begin
        wait_for_digests();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_short_text();
    test_byte_extremes();
    test_back_to_back();
    test_output_backpressure();
    test_random_messages();
    wait_for_digests();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
